>>> rtl/sha1_pkg.sv
package sha1_pkg;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          QDEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_of_message;
    } t_item;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_EMIT
    } t_state;
endpackage

>>> rtl/sha1_front.sv
module sha1_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha1_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output sha1_pkg::t_item o_item,
    input  logic           i_take
);
    import sha1_pkg::*;

    t_item      r_q [QDEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 3'(QDEPTH));
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 2'd1;
            if (w_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_wr) - 3'(w_rd);
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(QDEPTH)) else $error("queue overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        2'(r_wp - r_rp) == r_cnt[1:0]) else $error("pointer mismatch");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_rd |=> o_full) else $error("full dropped");
endmodule

>>> rtl/sha1_core.sv
module sha1_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sha1_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_empty,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word,
    input  logic            i_pop
);
    import sha1_pkg::*;

    t_state      r_st, n_st;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [6:0]  r_rnd;
    logic [2:0]  r_len, r_oi;
    logic        r_fin, r_padded, r_lendone;

    logic        w_byte_en, w_comp_start, w_comp_done;
    logic [7:0]  w_byte;
    logic [31:0] w_f, w_k, w_t, w_new;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_DATA: if (i_valid) begin
                if (i_item.has_data && r_pos == 6'd63) n_st = ST_COMP;
                else if (i_item.end_of_message) n_st = ST_PAD;
            end
            ST_PAD:  if (r_pos == 6'd63) n_st = ST_COMP;
                     else if (r_pos == 6'd55) n_st = ST_LEN;
            ST_LEN:  if (r_len == 3'd7) n_st = ST_COMP;
            ST_COMP: if (w_comp_done) begin
                if (!r_fin) n_st = ST_DATA;
                else if (r_lendone) n_st = ST_EMIT;
                else n_st = ST_PAD;
            end
            ST_EMIT: if (i_pop && r_oi == 3'd4) n_st = ST_DATA;
            default: n_st = ST_DATA;
        endcase
    end

    always_comb begin
        o_take    = (r_st == ST_DATA);
        w_byte_en = 1'b0;
        w_byte    = 8'd0;
        case (r_st)
            ST_DATA: begin
                w_byte_en = i_valid && i_item.has_data;
                w_byte    = i_item.data_byte;
            end
            ST_PAD: begin
                w_byte_en = 1'b1;
                w_byte    = r_padded ? 8'd0 : PAD_BYTE;
            end
            ST_LEN: begin
                w_byte_en = 1'b1;
                w_byte    = r_bits[8'(63 - 8 * r_len) -: 8];
            end
            default: ;
        endcase
    end

    assign w_comp_start = (r_st != ST_COMP) && (n_st == ST_COMP);
    assign w_comp_done  = (r_st == ST_COMP) && (r_rnd == 7'd80);

    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
        w_t   = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_byte_en) begin
            r_w[r_pos[5:2]][8'(31 - 8 * r_pos[1:0]) -: 8] <= w_byte;
        end
        if (w_comp_start) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
        end
        if (r_st == ST_COMP && !w_comp_done) begin
            r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]}; r_b <= r_a; r_a <= w_t;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= {w_new[30:0], w_new[31]};
        end
        if (!i_rst_n) begin
            r_st <= ST_DATA;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
            r_pos <= '0; r_bits <= '0; r_rnd <= '0; r_len <= '0; r_oi <= '0;
            r_fin <= 1'b0; r_padded <= 1'b0; r_lendone <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_byte_en) r_pos <= r_pos + 6'd1;
            if (r_st == ST_DATA && i_valid && i_item.has_data) r_bits <= r_bits + 64'd8;
            if (r_st == ST_DATA && i_valid && i_item.end_of_message) r_fin <= 1'b1;
            if (r_st == ST_PAD) r_padded <= 1'b1;
            if (r_st == ST_LEN) r_len <= r_len + 3'd1;
            if (r_st == ST_LEN && r_len == 3'd7) r_lendone <= 1'b1;
            if (r_st == ST_COMP) r_rnd <= w_comp_done ? 7'd0 : r_rnd + 7'd1;
            if (w_comp_done) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b; r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d; r_h[4] <= r_h[4] + r_e;
            end
            if (r_st == ST_EMIT && i_pop) begin
                if (r_oi == 3'd4) begin
                    r_oi <= '0; r_fin <= 1'b0; r_padded <= 1'b0; r_lendone <= 1'b0;
                    r_bits <= '0;
                    r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
                end else begin
                    r_oi <= r_oi + 3'd1;
                end
            end
        end
    end

    assign o_empty       = (r_st != ST_EMIT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'd4);

    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_COMP |-> r_rnd == 7'd0) else $error("round count stray");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> r_fin) else $error("digest without message end");
    a_oi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oi <= 3'd4) else $error("word index range");
endmodule

>>> rtl/sha1_stream_hasher.sv
// After the end-of-message transaction the core pads the block and runs a closing compression
// before the first digest word, and a second one when the padding does not fit that block.
// Throughput: one transaction per cycle while a 64-byte block fills; no transaction is taken
// while its rounds run; digest words one per cycle while i_pop is held.
// Reset: synchronous active low; chaining words return to initial values, queue empties.
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_data,
    input  logic        i_end_of_message,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1_pkg::*;

    t_item w_in, w_q;
    logic  w_valid, w_take;

    assign w_in = '{data_byte: i_data_byte, has_data: i_has_data,
                    end_of_message: i_end_of_message};

    sha1_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_item(w_in), .o_full,
        .o_valid(w_valid), .o_item(w_q), .i_take(w_take)
    );

    sha1_core u_core (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_item(w_q), .o_take(w_take),
        .o_empty, .o_digest_word, .o_word_index, .o_last_word, .i_pop
    );
endmodule
